// ----- src/patm_pkg.sv -----
// shared types and constants for the pedal auto-range torque map
package patm_pkg;

  // channel order: throttle_a, throttle_b, brake_a, brake_b
  localparam int NUM_CH   = 4;
  localparam int CH_W     = 2;
  localparam int LEVEL_W  = 16;
  localparam int Q16_W    = 17;

  // apb register port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // register reset values
  localparam logic [LEVEL_W-1:0] MIN_SPAN_RST    = 16'd500;
  localparam logic [LEVEL_W-1:0] LOWER_BOUND_RST = 16'd6554;
  localparam logic [LEVEL_W-1:0] TORQUE_FULL_RST = 16'd240;

  // register indexes (byte address 4*i)
  typedef enum logic [1:0] {
    REG_MIN_SPAN    = 2'd0,
    REG_LOWER_BOUND = 2'd1,
    REG_TORQUE_FULL = 2'd2
  } reg_idx_t;

  // configuration bundle from the register file to the datapath
  typedef struct packed {
    logic [LEVEL_W-1:0] min_span;
    logic [LEVEL_W-1:0] lower_bound;
    logic [LEVEL_W-1:0] torque_full;
  } cfg_t;

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UPDATE = 8'b0000_0010,
    S_LOAD   = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_AVG    = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_TORQ   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

endpackage

// ----- src/patm_in_if.sv -----
// pedal sample channel
interface patm_in_if;
  logic                         valid;
  logic                         ready;
  logic [patm_pkg::LEVEL_W-1:0] throttle_a;
  logic [patm_pkg::LEVEL_W-1:0] throttle_b;
  logic [patm_pkg::LEVEL_W-1:0] brake_a;
  logic [patm_pkg::LEVEL_W-1:0] brake_b;
  logic                         calibrating;

  modport source (
    output valid, throttle_a, throttle_b, brake_a, brake_b, calibrating,
    input  ready
  );
  modport sink (
    input  valid, throttle_a, throttle_b, brake_a, brake_b, calibrating,
    output ready
  );
endinterface

// ----- src/patm_out_if.sv -----
// torque and level result channel
interface patm_out_if;
  logic                         valid;
  logic                         ready;
  logic [patm_pkg::LEVEL_W-1:0] torque_command;
  logic [patm_pkg::LEVEL_W-1:0] brake_level;
  logic [patm_pkg::LEVEL_W-1:0] throttle_level;
  logic                         led_toggle;

  modport source (
    output valid, torque_command, brake_level, throttle_level, led_toggle,
    input  ready
  );
  modport sink (
    input  valid, torque_command, brake_level, throttle_level, led_toggle,
    output ready
  );
endinterface

// ----- src/patm_regs.sv -----
// apb configuration register file
module patm_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [patm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [patm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [patm_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output patm_pkg::cfg_t                  cfg
);

  patm_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = patm_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_span    <= patm_pkg::MIN_SPAN_RST;
      cfg.lower_bound <= patm_pkg::LOWER_BOUND_RST;
      cfg.torque_full <= patm_pkg::TORQUE_FULL_RST;
    end else if (wr_en) begin
      unique case (idx)
        patm_pkg::REG_MIN_SPAN:    cfg.min_span    <= pwdata[patm_pkg::LEVEL_W-1:0];
        patm_pkg::REG_LOWER_BOUND: cfg.lower_bound <= pwdata[patm_pkg::LEVEL_W-1:0];
        patm_pkg::REG_TORQUE_FULL: cfg.torque_full <= pwdata[patm_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      patm_pkg::REG_MIN_SPAN:    prdata = patm_pkg::APB_DATA_W'(cfg.min_span);
      patm_pkg::REG_LOWER_BOUND: prdata = patm_pkg::APB_DATA_W'(cfg.lower_bound);
      patm_pkg::REG_TORQUE_FULL: prdata = patm_pkg::APB_DATA_W'(cfg.torque_full);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ----- src/patm_div.sv -----
// shared restoring divider: clamp(floor(diff * ONE / span), ONE), one bit a cycle
module patm_div #(
  parameter int RAW_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [RAW_BITS-1:0] diff,
  input  logic [RAW_BITS-1:0] span,
  output logic                done,
  output logic [FRAC_BITS:0]  quot
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [RAW_BITS-1:0] rem;
  logic [RAW_BITS-1:0] dsr;
  logic [RAW_BITS:0]   rem2;
  logic                qbit;

  // trial subtract of the doubled remainder
  assign rem2 = {rem, 1'b0};
  assign qbit = (rem2 >= {1'b0, dsr});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if ((span == '0) || (diff >= span)) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(FRAC_BITS);
        end
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder; zero span gives 0, diff at or over span saturates
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= span;
      rem <= diff;
      if (span == '0) begin
        quot <= '0;
      end else if (diff >= span) begin
        quot <= {1'b1, {FRAC_BITS{1'b0}}};
      end else begin
        quot <= '0;
      end
    end else if (busy) begin
      rem  <= qbit ? RAW_BITS'(rem2 - {1'b0, dsr}) : rem2[RAW_BITS-1:0];
      quot <= {1'b0, quot[FRAC_BITS-2:0], qbit};
    end
  end

endmodule

// ----- src/pedal_autorange_torque_map_core.sv -----
// pedal auto-range and torque map: top level with sequencer and datapath
// sequence: per sample, update ranges, then for each channel load and run the shared divider,
//   one bit a cycle, which ends early for a zero span or offset >= span; then average, multiply, torque, output
// throughput: one sample at a time, the next taken the cycle after the result is taken
// reset: synchronous, clears sequencer, ranges (min all ones, max zero), last torque, registers
module pedal_autorange_torque_map_core #(
  parameter int RAW_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  patm_in_if.sink                         in_ch,
  patm_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [patm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [patm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [patm_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int NW    = FRAC_BITS + 1;
  localparam int LW    = patm_pkg::LEVEL_W;
  localparam int QW    = patm_pkg::Q16_W;
  localparam int NCH   = patm_pkg::NUM_CH;
  localparam int CW    = patm_pkg::CH_W;
  localparam int SH_UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int SH_DN = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int TW    = NW + SH_UP;
  localparam int PW    = NW + LW;
  localparam int P5W   = PW + 3;
  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
  localparam logic [NW-1:0] ONE_TENTH   = NW'((ONE + 64'd5) / 64'd10);
  localparam logic [NW-1:0] NINE_TENTHS = NW'((64'd9 * ONE + 64'd5) / 64'd10);

  patm_pkg::cfg_t   cfg;
  patm_pkg::state_t state;

  logic [RAW_BITS-1:0] raw    [NCH];
  logic [RAW_BITS-1:0] ch_min [NCH];
  logic [RAW_BITS-1:0] ch_max [NCH];
  logic [RAW_BITS-1:0] span_w [NCH];
  logic [NW-1:0]       norm   [NCH];
  logic                cal;
  logic [CW-1:0]       ch;
  logic [1:0]          pair_bad;

  logic [RAW_BITS-1:0] div_diff;
  logic                div_start;
  logic                div_done;
  logic [NW-1:0]       div_quot;

  logic [NW-1:0]       thr;
  logic [NW-1:0]       brk;
  logic [TW-1:0]       thr_wide;
  logic [TW-1:0]       brk_wide;
  logic [QW-1:0]       thr16;
  logic [QW-1:0]       brk16;
  logic [PW-1:0]       prod;
  logic [P5W-1:0]      prod5;
  logic [P5W-1:0]      torq_raw;
  logic [LW-1:0]       torq_sat;
  logic                db_pass;
  logic                thr_full;
  logic                thr_low;
  logic                led;
  logic [LW-1:0]       last_torque;
  logic [LW-1:0]       torque_next;

  logic                out_valid;
  logic [LW-1:0]       torque_command;
  logic [LW-1:0]       brake_level;
  logic [LW-1:0]       throttle_level;
  logic                led_toggle;

  // configuration registers
  patm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // span of each channel, zero when max is not above min
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      span_w[i] = (ch_max[i] > ch_min[i]) ? RAW_BITS'(ch_max[i] - ch_min[i]) : '0;
    end
    pair_bad[0] = (LW'(span_w[0]) < cfg.min_span) || (LW'(span_w[1]) < cfg.min_span);
    pair_bad[1] = (LW'(span_w[2]) < cfg.min_span) || (LW'(span_w[3]) < cfg.min_span);
  end

  // divider operands for the current channel
  assign div_diff  = (raw[ch] >= ch_min[ch]) ? RAW_BITS'(raw[ch] - ch_min[ch])
                                             : RAW_BITS'(ch_min[ch] - raw[ch]);
  assign div_start = (state == patm_pkg::S_LOAD);

  patm_div #(
    .RAW_BITS  (RAW_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .diff  (div_diff),
    .span  (span_w[ch]),
    .done  (div_done),
    .quot  (div_quot)
  );

  // conversion of the pair averages to q0.16
  assign thr_wide = TW'(thr) << SH_UP;
  assign brk_wide = TW'(brk) << SH_UP;
  assign thr16    = QW'(thr_wide >> SH_DN);
  assign brk16    = QW'(brk_wide >> SH_DN);

  // torque scaling: prod * 5 / (4 * ONE)
  assign prod5    = (P5W'(prod) << 2) + P5W'(prod);
  assign torq_raw = prod5 >> (FRAC_BITS + 2);
  assign torq_sat = (torq_raw > P5W'({LW{1'b1}})) ? {LW{1'b1}} : LW'(torq_raw);

  always_comb begin
    if (!db_pass) begin
      torque_next = '0;
    end else if (thr_full) begin
      torque_next = cfg.torque_full;
    end else if (thr_low) begin
      torque_next = '0;
    end else begin
      torque_next = torq_sat;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= patm_pkg::S_IDLE;
      ch          <= '0;
      out_valid   <= 1'b0;
      last_torque <= '0;
      for (int i = 0; i < NCH; i++) begin
        ch_min[i] <= {RAW_BITS{1'b1}};
        ch_max[i] <= '0;
      end
    end else begin
      unique case (state)
        patm_pkg::S_IDLE: begin
          if (in_ch.valid) begin
            state <= patm_pkg::S_UPDATE;
          end
        end
        patm_pkg::S_UPDATE: begin
          // track ranges while calibrating, else collapse a weak pair
          if (cal) begin
            for (int i = 0; i < NCH; i++) begin
              if (raw[i] < ch_min[i]) ch_min[i] <= raw[i];
              if (raw[i] > ch_max[i]) ch_max[i] <= raw[i];
            end
          end else begin
            for (int p = 0; p < 2; p++) begin
              if (pair_bad[p]) begin
                ch_min[2*p]   <= RAW_BITS'(1);
                ch_max[2*p]   <= RAW_BITS'(1);
                ch_min[2*p+1] <= RAW_BITS'(1);
                ch_max[2*p+1] <= RAW_BITS'(1);
              end
            end
          end
          ch    <= '0;
          state <= patm_pkg::S_LOAD;
        end
        patm_pkg::S_LOAD: begin
          state <= patm_pkg::S_DIV;
        end
        patm_pkg::S_DIV: begin
          if (div_done) begin
            if (ch == CW'(NCH - 1)) begin
              state <= patm_pkg::S_AVG;
            end else begin
              ch    <= ch + 1'b1;
              state <= patm_pkg::S_LOAD;
            end
          end
        end
        patm_pkg::S_AVG: begin
          state <= patm_pkg::S_MUL;
        end
        patm_pkg::S_MUL: begin
          state <= patm_pkg::S_TORQ;
        end
        patm_pkg::S_TORQ: begin
          last_torque <= torque_next;
          out_valid   <= 1'b1;
          state       <= patm_pkg::S_OUT;
        end
        patm_pkg::S_OUT: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            state     <= patm_pkg::S_IDLE;
          end
        end
        default: state <= patm_pkg::S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state == patm_pkg::S_IDLE) && in_ch.valid) begin
      raw[0] <= in_ch.throttle_a[RAW_BITS-1:0];
      raw[1] <= in_ch.throttle_b[RAW_BITS-1:0];
      raw[2] <= in_ch.brake_a[RAW_BITS-1:0];
      raw[3] <= in_ch.brake_b[RAW_BITS-1:0];
      cal    <= in_ch.calibrating;
    end
    if ((state == patm_pkg::S_DIV) && div_done) begin
      norm[ch] <= div_quot;
    end
    // pair averages
    if (state == patm_pkg::S_AVG) begin
      thr <= NW'(({1'b0, norm[0]} + {1'b0, norm[1]}) >> 1);
      brk <= NW'(({1'b0, norm[2]} + {1'b0, norm[3]}) >> 1);
    end
    // threshold flags and the torque product
    if (state == patm_pkg::S_MUL) begin
      db_pass  <= (thr16 > QW'(cfg.lower_bound));
      thr_full <= (thr >= NINE_TENTHS);
      thr_low  <= (thr <= ONE_TENTH);
      led      <= (last_torque == '0) && (thr >= NINE_TENTHS);
      prod     <= PW'(thr - ONE_TENTH) * PW'(cfg.torque_full);
    end
    // result word
    if (state == patm_pkg::S_TORQ) begin
      torque_command <= torque_next;
      brake_level    <= (brk16 > QW'({LW{1'b1}})) ? {LW{1'b1}} : LW'(brk16);
      throttle_level <= (thr16 > QW'({LW{1'b1}})) ? {LW{1'b1}} : LW'(thr16);
      led_toggle     <= led;
    end
  end

  // channel outputs
  assign in_ch.ready           = (state == patm_pkg::S_IDLE);
  assign out_ch.valid          = out_valid;
  assign out_ch.torque_command = torque_command;
  assign out_ch.brake_level    = brake_level;
  assign out_ch.throttle_level = throttle_level;
  assign out_ch.led_toggle     = led_toggle;

endmodule

// ----- test/patm_checker.sv -----
// checker for the pedal torque map: predicts every result word and compares it
`timescale 1ns / 100ps
module patm_checker
  import patm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  patm_in_if                    in_ch,
  patm_out_if                   out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending
);

  // travel is q0.16 held in 17 bits so that 1.0 fits
  localparam logic [16:0] TRAVEL_ONE   = 17'h10000;
  localparam logic [16:0] FULL_TRAVEL  = 17'((9 * 65536 + 5) / 10);
  localparam logic [16:0] TENTH_TRAVEL = 17'((65536 + 5) / 10);

  typedef struct packed {
    logic [LEVEL_W-1:0] torque;
    logic [LEVEL_W-1:0] brake;
    logic [LEVEL_W-1:0] throttle;
    logic               led;
  } torque_frame_t;

  // learnt sensor ranges, previous torque and register copies
  logic [LEVEL_W-1:0] rng_lo [NUM_CH];
  logic [LEVEL_W-1:0] rng_hi [NUM_CH];
  logic [LEVEL_W-1:0] prev_torque;
  logic [LEVEL_W-1:0] min_span_r;
  logic [LEVEL_W-1:0] lower_bound_r;
  logic [LEVEL_W-1:0] torque_full_r;

  torque_frame_t frame_q [$];

  task automatic report_fail(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [LEVEL_W-1:0] got,
                             input logic [LEVEL_W-1:0] want);
    if (got !== want)
      report_fail($sformatf("%s mismatch: got %h, expected %h", name, got, want));
  endtask

  function automatic logic [LEVEL_W-1:0] span_of(input int c);
    return (rng_hi[c] > rng_lo[c]) ? rng_hi[c] - rng_lo[c] : '0;
  endfunction

  // |raw - min| / span, floored, clamped at 1.0; an empty span reads as zero travel
  function automatic logic [16:0] travel_of(input int c, input logic [LEVEL_W-1:0] raw);
    logic [31:0] offset;
    logic [31:0] span;
    logic [31:0] quot;
    span = 32'(span_of(c));
    offset = (raw >= rng_lo[c]) ? 32'(raw - rng_lo[c]) : 32'(rng_lo[c] - raw);
    if (span == 0) return '0;
    quot = (offset << 16) / span;
    return (quot > 32'(TRAVEL_ONE)) ? TRAVEL_ONE : quot[16:0];
  endfunction

  // one pedal word: range update or pair check, then levels and torque
  function automatic torque_frame_t map_sample(input logic [NUM_CH-1:0][LEVEL_W-1:0] raw,
                                               input logic cal);
    torque_frame_t res;
    logic [16:0] thr;
    logic [16:0] brk;
    logic [63:0] trq;
    if (cal) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (raw[c] < rng_lo[c]) rng_lo[c] = raw[c];
        if (raw[c] > rng_hi[c]) rng_hi[c] = raw[c];
      end
    end else begin
      // a pair with either span short of the minimum loses its range
      for (int c = 0; c < NUM_CH; c += 2) begin
        if (span_of(c) < min_span_r || span_of(c + 1) < min_span_r) begin
          rng_lo[c]     = 16'd1;
          rng_hi[c]     = 16'd1;
          rng_lo[c + 1] = 16'd1;
          rng_hi[c + 1] = 16'd1;
        end
      end
    end
    thr = 17'((18'(travel_of(0, raw[0])) + 18'(travel_of(1, raw[1]))) >> 1);
    brk = 17'((18'(travel_of(2, raw[2])) + 18'(travel_of(3, raw[3]))) >> 1);
    res.led = (prev_torque == '0) && (thr >= FULL_TRAVEL);
    // deadband, then full torque at 0.9, then the linear part above 0.1
    if (thr > 17'(lower_bound_r)) begin
      if (thr >= FULL_TRAVEL)
        trq = 64'(torque_full_r);
      else if (thr <= TENTH_TRAVEL)
        trq = '0;
      else
        trq = (64'(thr - TENTH_TRAVEL) * 64'(torque_full_r) * 64'd5) /
              (64'd4 * 64'(TRAVEL_ONE));
    end else begin
      trq = '0;
    end
    res.torque   = (trq > 64'hffff) ? 16'hffff : trq[15:0];
    res.brake    = (brk > 17'hffff) ? 16'hffff : brk[15:0];
    res.throttle = (thr > 17'hffff) ? 16'hffff : thr[15:0];
    prev_torque  = res.torque;
    return res;
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin
    torque_frame_t want;
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rng_lo[c] = '1;
        rng_hi[c] = '0;
      end
      prev_torque   = '0;
      min_span_r    = MIN_SPAN_RST;
      lower_bound_r = LOWER_BOUND_RST;
      torque_full_r = TORQUE_FULL_RST;
      frame_q.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_q.size() == 0) begin
          report_fail($sformatf("result word with none expected, torque %h",
                                out_ch.torque_command));
        end else begin
          want = frame_q.pop_front();
          check_field("torque_command", out_ch.torque_command, want.torque);
          check_field("brake_level", out_ch.brake_level, want.brake);
          check_field("throttle_level", out_ch.throttle_level, want.throttle);
          check_field("led_toggle", 16'(out_ch.led_toggle), 16'(want.led));
        end
      end
      if (in_ch.valid && in_ch.ready)
        frame_q.push_back(map_sample({in_ch.brake_b, in_ch.brake_a,
                                      in_ch.throttle_b, in_ch.throttle_a},
                                     in_ch.calibrating));
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MIN_SPAN:    min_span_r    = pwdata[LEVEL_W-1:0];
          REG_LOWER_BOUND: lower_bound_r = pwdata[LEVEL_W-1:0];
          REG_TORQUE_FULL: torque_full_r = pwdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
    pending = frame_q.size();
  end

endmodule

// ----- test/tb_pedal_autorange_torque_map_core.sv -----
// testbench top: pedal words, register writes, handshake stalls and the verdict
`timescale 1ns / 100ps
module tb_pedal_autorange_torque_map_core;
  import patm_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 100;
  localparam int RUN_PHASES   = 7;
  localparam int PHASE_WORDS  = 85;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;

  // stimulus shaping: stall switch, hold-off request, window of each sensor
  bit quiet;
  int hold_cycles;
  int win_lo [NUM_CH];
  int win_hi [NUM_CH];
  int lb_now;

  patm_in_if  in_ch ();
  patm_out_if out_ch ();

  pedal_autorange_torque_map_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  patm_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, and a long hold-off when asked for
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else if (quiet || $urandom_range(0, 3) == 0) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 11);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [LEVEL_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LOWER_BOUND) lb_now = int'(val);
  endtask

  // offer one pedal word after a random gap and wait for it to be taken
  task automatic send_sample(input logic [LEVEL_W-1:0] ta, input logic [LEVEL_W-1:0] tb,
                             input logic [LEVEL_W-1:0] ba, input logic [LEVEL_W-1:0] bb,
                             input logic cal);
    int gap;
    int raw [NUM_CH];
    raw[0] = int'(ta);
    raw[1] = int'(tb);
    raw[2] = int'(ba);
    raw[3] = int'(bb);
    gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.throttle_a  <= ta;
    in_ch.throttle_b  <= tb;
    in_ch.brake_a     <= ba;
    in_ch.brake_b     <= bb;
    in_ch.calibrating <= cal;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    if (cal) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (raw[c] < win_lo[c]) win_lo[c] = raw[c];
        if (raw[c] > win_hi[c]) win_hi[c] = raw[c];
      end
    end
  endtask

  // sender pause until every result word is back
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // pedal travel in q0.16, weighted towards the map's corners
  function automatic int pick_travel();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 65535;
      2:       return 58982 + int'($urandom_range(0, 400)) - 200;
      3:       return lb_now + int'($urandom_range(0, 600)) - 300;
      4:       return 6554 + int'($urandom_range(0, 400)) - 200;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  // raw reading for a travel within the sensor's window, with some jitter
  function automatic logic [LEVEL_W-1:0] pedal_raw(input int c, input int p);
    longint v;
    v = win_lo[c] + ((longint'(win_hi[c] - win_lo[c]) * p) >>> 16);
    if ($urandom_range(0, 1) == 1) v = v + int'($urandom_range(0, 64)) - 32;
    if ($urandom_range(0, 15) == 0) v = win_hi[c] + int'($urandom_range(0, 3000));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // directed words: zero spans, short pair, below-min reading, over range,
  // deadband, sub-tenth travel, the 0.9 edge, all-ones and alternating bits
  task automatic run_directed();
    send_sample(16'd1000, 16'd1200, 16'd2000, 16'd2200, 1'b1);
    send_sample(16'd9000, 16'd9200, 16'd3000, 16'd2300, 1'b1);
    send_sample(16'd1000, 16'd1200, 16'd2500, 16'd2250, 1'b0);
    send_sample(16'd9000, 16'd9200, 16'd2500, 16'd2250, 1'b0);
    send_sample(16'd9000, 16'd9200, 16'd2500, 16'd2250, 1'b0);
    send_sample(16'd0, 16'd30000, 16'd0, 16'd65535, 1'b0);
    send_sample(16'd5000, 16'd5200, 16'd2500, 16'd2250, 1'b0);
    send_sample(16'd1500, 16'd1800, 16'd2500, 16'd2250, 1'b0);
    wait_results();
    apb_write(REG_LOWER_BOUND, 16'd0);
    send_sample(16'd1500, 16'd1800, 16'd2500, 16'd2250, 1'b0);
    wait_results();
    apb_write(REG_TORQUE_FULL, 16'hffff);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    // one sensor of each pair stays just short of full scale
    send_sample(16'hffff, 16'hfffe, 16'hfffe, 16'hffff, 1'b1);
    send_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 1'b0);
    send_sample(16'd58982, 16'd58982, 16'd30000, 16'd30000, 1'b0);
    send_sample(16'd58980, 16'd58980, 16'd30000, 16'd30000, 1'b0);
    send_sample(16'd20000, 16'd40000, 16'd12345, 16'd54321, 1'b1);
    send_sample(16'd6554, 16'd6554, 16'd6554, 16'd6554, 1'b0);
    wait_results();
  endtask

  // one random phase: clear ranges, set registers, calibrate, then drive the pedal
  task automatic run_phase(input int ph);
    logic [LEVEL_W-1:0] ms;
    logic [LEVEL_W-1:0] lb;
    logic [LEVEL_W-1:0] tf;
    int clo [NUM_CH];
    int chi [NUM_CH];
    int raw [NUM_CH];
    int n_cal;
    int pt;
    int pb;
    case (ph)
      0: begin
        ms = MIN_SPAN_RST;
        lb = LOWER_BOUND_RST;
        tf = TORQUE_FULL_RST;
      end
      1: begin
        ms = 16'd0;
        lb = 16'd0;
        tf = 16'hffff;
      end
      2: begin
        ms = 16'($urandom_range(0, 2000));
        lb = 16'hffff;
        tf = 16'($urandom_range(0, 65535));
      end
      default: begin
        ms = 16'($urandom_range(0, 4000));
        lb = 16'($urandom_range(0, 20000));
        tf = 16'($urandom_range(0, 65535));
      end
    endcase
    // the widest minimum span makes every pair short of full scale collapse on a running word
    wait_results();
    apb_write(REG_MIN_SPAN, 16'hffff);
    send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    wait_results();
    for (int c = 0; c < NUM_CH; c++) begin
      win_lo[c] = 1;
      win_hi[c] = 1;
    end
    apb_write(REG_MIN_SPAN, ms);
    apb_write(REG_LOWER_BOUND, lb);
    apb_write(REG_TORQUE_FULL, tf);
    quiet = (ph == 3);
    // calibration targets, now and then a pair left short of the minimum
    for (int c = 0; c < NUM_CH; c++) begin
      clo[c] = $urandom_range(0, 1);
      if (c % 2 == 1 && $urandom_range(0, 4) == 0)
        chi[c] = 1 + int'($urandom_range(0, ms));
      else
        chi[c] = $urandom_range(2000, 65535);
    end
    n_cal = $urandom_range(2, 6);
    for (int k = 0; k < n_cal; k++) begin
      for (int c = 0; c < NUM_CH; c++)
        raw[c] = (k == 0) ? clo[c] : (k == 1) ? chi[c] : $urandom_range(clo[c], chi[c]);
      send_sample(16'(raw[0]), 16'(raw[1]), 16'(raw[2]), 16'(raw[3]), 1'b1);
    end
    // running words: mostly pedal travel, some noise and stray calibration
    for (int k = 0; k < PHASE_WORDS; k++) begin
      if (ph == 1 && k == 20) hold_cycles = LONG_HOLD;
      if (ph == 4 && k == 40) wait_results();
      case ($urandom_range(0, 19))
        0, 1: send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          1'($urandom));
        2: begin
          pt = pick_travel();
          pb = pick_travel();
          send_sample(pedal_raw(0, pt), pedal_raw(1, pt), pedal_raw(2, pb),
                      pedal_raw(3, pb), 1'b1);
        end
        default: begin
          pt = pick_travel();
          pb = pick_travel();
          send_sample(pedal_raw(0, pt), pedal_raw(1, pt), pedal_raw(2, pb),
                      pedal_raw(3, pb), 1'b0);
        end
      endcase
    end
    quiet = 1'b0;
  endtask

  // reset, stimulus and verdict
  initial begin
    rst = 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.throttle_a  <= '0;
    in_ch.throttle_b  <= '0;
    in_ch.brake_a     <= '0;
    in_ch.brake_b     <= '0;
    in_ch.calibrating <= 1'b0;
    quiet = 1'b0;
    hold_cycles = 0;
    lb_now = int'(LOWER_BOUND_RST);
    for (int c = 0; c < NUM_CH; c++) begin
      win_lo[c] = 65535;
      win_hi[c] = 0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    for (int ph = 0; ph < RUN_PHASES; ph++)
      run_phase(ph);
    wait_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/patm_pkg.sv
src/patm_in_if.sv
src/patm_out_if.sv
src/patm_regs.sv
src/patm_div.sv
src/pedal_autorange_torque_map_core.sv
test/patm_checker.sv
test/tb_pedal_autorange_torque_map_core.sv
